FILE: design/illp_pkg.sv
// Package for the image list line parser: phase encoding, result kinds,
// result queue entry type and the keyword tables.
// Has no dependencies; used by image_list_line_parser_top.
package illp_pkg;

    typedef enum logic [10:0] {
        PH_LEAD     = 11'b000_0000_0001,
        PH_KEY      = 11'b000_0000_0010,
        PH_AFTERKEY = 11'b000_0000_0100,
        PH_BRACKET  = 11'b000_0000_1000,
        PH_SEP      = 11'b000_0001_0000,
        PH_WS1      = 11'b000_0010_0000,
        PH_SRC      = 11'b000_0100_0000,
        PH_WS2      = 11'b000_1000_0000,
        PH_TGT      = 11'b001_0000_0000,
        PH_DONE     = 11'b010_0000_0000,
        PH_IGNORE   = 11'b100_0000_0000
    } phase_t;

    localparam logic [1:0] KIND_SRC     = 2'd0;
    localparam logic [1:0] KIND_TGT     = 2'd1;
    localparam logic [1:0] KIND_COMMIT  = 2'd2;
    localparam logic [1:0] KIND_DISCARD = 2'd3;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam int NUM_KW = 8;

    typedef struct packed {
        logic       last;
        logic [1:0] kind;
        logic [7:0] ch;
    } res_entry_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0C);
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] len;
        case (k)
            3'd0:    len = 4'd7;
            3'd1:    len = 4'd9;
            3'd2:    len = 4'd9;
            3'd3:    len = 4'd7;
            3'd4:    len = 4'd6;
            3'd5:    len = 4'd4;
            3'd6:    len = 4'd4;
            default: len = 4'd3;
        endcase
        return len;
    endfunction

    // Keyword text right-aligned: the first character sits in the highest used byte.
    function automatic logic [71:0] kw_row(input logic [2:0] k);
        logic [71:0] row;
        case (k)
            3'd0:    row = 72'("primary");
            3'd1:    row = 72'("secondary");
            3'd2:    row = 72'("extension");
            3'd3:    row = 72'("variant");
            3'd4:    row = 72'("device");
            3'd5:    row = 72'("file");
            3'd6:    row = 72'("data");
            default: row = 72'("dll");
        endcase
        return row;
    endfunction

    // True when keyword k holds character c at position pos.
    function automatic logic kw_match(input logic [2:0] k, input logic [3:0] pos,
                                      input logic [7:0] c);
        logic [71:0] row;
        logic [3:0]  len;
        logic [6:0]  sh;
        logic        hit;
        row = kw_row(k);
        len = kw_len(k);
        hit = 1'b0;
        sh  = 7'd0;
        if (pos < len)
        begin
            sh  = {len - 4'd1 - pos, 3'b000};
            hit = (row[sh +: 8] == c);
        end
        return hit;
    endfunction

endpackage

FILE: design/image_list_line_parser_top.sv
// Image list line parser top level: per-byte line parsing and a small result queue.
// Depends on illp_pkg.
//
//  channel  dir  tdata               tuser      tlast
//  s_axis   in   [7:0] in_byte       -          last_byte
//  m_axis   out  [7:0] out_char      [1:0] kind last_result
//
// Each accepted byte is parsed in the cycle it arrives; its zero to two results are
// written into a four-entry queue that drains one result per cycle while the output is ready.
// A byte is taken whenever the queue has room for two results, so bytes stream at one
// per cycle as long as the output keeps up; a byte yielding two results leaves as two results.
// The asynchronous active-low reset clears the parser state and empties the queue.
module image_list_line_parser_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast
);
    import illp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  alive_reg, alive_next;
    logic [3:0]  pos_reg, pos_next;
    logic        quoted_reg, quoted_next;
    logic        first_reg, first_next;
    logic        skip_reg, skip_next;
    logic        pending_reg, pending_next;

    res_entry_t  queue_reg [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg;

    logic        accept, pop;
    logic [7:0]  c;
    logic        sep;
    logic [1:0]  n_res;
    res_entry_t  res0, res1;
    logic [7:0]  alive_key;
    logic [3:0]  pos_key;
    logic        hit_key;
    logic [1:0]  name_kind;
    logic        end_name;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (count_reg <= 3'd2);
    assign m_axis_tvalid = (count_reg != 3'd0);
    assign m_axis_tdata  = queue_reg[rd_ptr_reg].ch;
    assign m_axis_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_axis_tlast  = queue_reg[rd_ptr_reg].last;

    assign c = (s_axis_tdata >= 8'h41 && s_axis_tdata <= 8'h5A) ?
               s_axis_tdata + 8'h20 : s_axis_tdata;
    assign sep = (c == CH_EQUAL) || (c == CH_SPACE) || (c == CH_TAB);

    // Keyword step; at line start the candidates restart from all alive at position zero.
    always_comb
    begin
        logic [7:0] alive_in;
        logic [3:0] pos_in;
        alive_in = (phase_reg == PH_LEAD) ? 8'hFF : alive_reg;
        pos_in   = (phase_reg == PH_LEAD) ? 4'd0 : pos_reg;
        pos_key  = pos_in + 4'd1;
        hit_key  = 1'b0;
        for (int k = 0; k < NUM_KW; k++)
        begin
            alive_key[k] = alive_in[k] && kw_match(3'(k), pos_in, c);
            if (alive_key[k] && kw_len(3'(k)) == pos_key)
            begin
                hit_key = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        alive_next   = alive_reg;
        pos_next     = pos_reg;
        quoted_next  = quoted_reg;
        first_next   = first_reg;
        skip_next    = skip_reg;
        pending_next = pending_reg;
        n_res        = 2'd0;
        res0         = '0;
        res1         = '0;
        name_kind    = (phase_reg == PH_WS2 || phase_reg == PH_TGT) ? KIND_TGT : KIND_SRC;
        end_name     = quoted_reg ? (c == CH_QUOTE) : is_ws(c);

        if (skip_reg)
        begin
            skip_next = 1'b0;
        end
        else if (c == CH_CR)
        begin
            if ((phase_reg == PH_TGT || phase_reg == PH_DONE) && !first_reg)
            begin
                n_res = 2'd1;
                res0  = '{last: 1'b0, kind: KIND_COMMIT, ch: 8'h00};
            end
            else if (pending_reg)
            begin
                n_res = 2'd1;
                res0  = '{last: 1'b0, kind: KIND_DISCARD, ch: 8'h00};
            end
            pending_next = 1'b0;
            phase_next   = PH_LEAD;
            alive_next   = 8'hFF;
            pos_next     = 4'd0;
            quoted_next  = 1'b0;
            first_next   = 1'b1;
            skip_next    = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_LEAD, PH_KEY:
                begin
                    if (phase_reg == PH_KEY || !is_ws(c))
                    begin
                        alive_next = alive_key;
                        pos_next   = pos_key;
                        if (alive_key == 8'h00)
                        begin
                            phase_next = PH_IGNORE;
                        end
                        else if (hit_key)
                        begin
                            phase_next = PH_AFTERKEY;
                        end
                        else
                        begin
                            phase_next = PH_KEY;
                        end
                    end
                end
                PH_AFTERKEY:
                begin
                    if (c == CH_LBRACK)
                    begin
                        phase_next = PH_BRACKET;
                    end
                    else
                    begin
                        phase_next = sep ? PH_WS1 : PH_IGNORE;
                    end
                end
                PH_BRACKET:
                begin
                    if (c == CH_RBRACK)
                    begin
                        phase_next = PH_SEP;
                    end
                end
                PH_SEP:
                begin
                    phase_next = sep ? PH_WS1 : PH_IGNORE;
                end
                PH_WS1, PH_WS2:
                begin
                    if (!is_ws(c))
                    begin
                        phase_next = (phase_reg == PH_WS1) ? PH_SRC : PH_TGT;
                        first_next = 1'b0;
                        if (c == CH_QUOTE)
                        begin
                            quoted_next = 1'b1;
                            first_next  = 1'b1;
                        end
                        else
                        begin
                            quoted_next = 1'b0;
                            if (c != CH_BSLASH)
                            begin
                                n_res        = 2'd1;
                                res0         = '{last: 1'b0, kind: name_kind, ch: c};
                                pending_next = 1'b1;
                            end
                        end
                    end
                end
                PH_SRC, PH_TGT:
                begin
                    if (end_name)
                    begin
                        phase_next = (phase_reg == PH_SRC) ? PH_WS2 : PH_DONE;
                    end
                    else
                    begin
                        first_next = 1'b0;
                        if (!(first_reg && c == CH_BSLASH))
                        begin
                            n_res        = 2'd1;
                            res0         = '{last: 1'b0, kind: name_kind, ch: c};
                            pending_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (s_axis_tlast)
        begin
            if (pending_next)
            begin
                if (n_res == 2'd0)
                begin
                    res0 = '{last: 1'b0, kind: KIND_DISCARD, ch: 8'h00};
                end
                else
                begin
                    res1 = '{last: 1'b0, kind: KIND_DISCARD, ch: 8'h00};
                end
                n_res = n_res + 2'd1;
            end
            phase_next   = PH_LEAD;
            alive_next   = 8'hFF;
            pos_next     = 4'd0;
            quoted_next  = 1'b0;
            first_next   = 1'b1;
            skip_next    = 1'b0;
            pending_next = 1'b0;
        end

        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        else if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            alive_reg   <= 8'hFF;
            pos_reg     <= 4'd0;
            quoted_reg  <= 1'b0;
            first_reg   <= 1'b1;
            skip_reg    <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            alive_reg   <= alive_next;
            pos_reg     <= pos_next;
            quoted_reg  <= quoted_next;
            first_reg   <= first_next;
            skip_reg    <= skip_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && n_res != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (accept && n_res == 2'd2)
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

endmodule
